>>> sv/lbnpc_pkg.sv
// ----------------------------------------------------------------------------
// lbnpc_pkg: shared types and constants of the night pulse controller
// Payload structs, event kinds, register indexes and reset values.
// ----------------------------------------------------------------------------
package lbnpc_pkg;

   localparam int DAY_COUNTER_BITS = 17;
   localparam int PULSE_LENGTH     = 2;
   localparam int MODE_SLOTS       = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;
   localparam int TICK_W      = 17;
   localparam int LEVEL_W     = 8;
   localparam int MODE_CNT_W  = 4;
   localparam int ZONE_W      = 3;
   localparam int SHOWN_W     = 3;
   localparam int LOAD_W      = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_DAY   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NIGHT_START     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NIGHT_END       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_BRIGHTNESS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIM_BRIGHTNESS  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_COUNT      = 3'd5;

   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_POLL   = 2'd1;
   localparam logic [1:0] KIND_BUTTON = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [TICK_W-1:0]     RST_TICKS_PER_DAY   = 17'd86400;
   localparam logic [TICK_W-1:0]     RST_NIGHT_START     = 17'd131071;
   localparam logic [TICK_W-1:0]     RST_NIGHT_END       = 17'd0;
   localparam logic [LEVEL_W-1:0]    RST_FULL_BRIGHTNESS = 8'd128;
   localparam logic [LEVEL_W-1:0]    RST_DIM_BRIGHTNESS  = 8'd64;
   localparam logic [MODE_CNT_W-1:0] RST_MODE_COUNT      = 4'd8;

   localparam logic [LOAD_W-1:0]  CAP_ZONE1_LOAD      = 6'd20;
   localparam logic [LOAD_W-1:0]  CAP_ZONE_OTHER_LOAD = 6'd5;
   localparam logic [LOAD_W-1:0]  CAP_LIMIT           = 6'd30;
   localparam logic [LEVEL_W-1:0] PULSE_LEVEL         = 8'd255;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ZONE_W-1:0] zone_levels;
   } req_payload_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] brightness;
      logic [SHOWN_W-1:0] shown_mode;
      logic               night;
      logic               refresh;
   } rsp_payload_type;

endpackage

>>> sv/led_brightness_night_pulse_controller_top.sv
// ----------------------------------------------------------------------------
// led_brightness_night_pulse_controller_top: night window and pulse control
// Tracks the day counter, night window, load cap, zone pulse and color mode.
// ----------------------------------------------------------------------------
//  channel   direction  transfer moves
//  req       in         one event: kind and zone levels
//  rsp       out        one result per event: brightness, mode, night, refresh
//  csr       in         one register write: index and data
//
// Each accepted event's result is registered and appears in the next cycle.
// One event per cycle is sustained while rsp_ready is high; the state update is a single pass of logic.
// The result register stalls req only while its result waits on rsp_ready; req is also not ready in reset.
// Reset is synchronous and loads the register defaults and cleared state.
// ----------------------------------------------------------------------------
module led_brightness_night_pulse_controller_top #(
   parameter int DAY_COUNTER_BITS = lbnpc_pkg::DAY_COUNTER_BITS,
   parameter int PULSE_LENGTH     = lbnpc_pkg::PULSE_LENGTH,
   parameter int MODE_SLOTS       = lbnpc_pkg::MODE_SLOTS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  lbnpc_pkg::req_payload_type            req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output lbnpc_pkg::rsp_payload_type            rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lbnpc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lbnpc_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int TICK_W  = lbnpc_pkg::TICK_W;
   localparam int LEVEL_W = lbnpc_pkg::LEVEL_W;
   localparam int ZONE_W  = lbnpc_pkg::ZONE_W;
   localparam int MCNT_W  = lbnpc_pkg::MODE_CNT_W;
   localparam int SHOWN_W = lbnpc_pkg::SHOWN_W;
   localparam int CMP_W   = (DAY_COUNTER_BITS > TICK_W) ? DAY_COUNTER_BITS : TICK_W;
   localparam int MODE_W  = (MODE_SLOTS > 1) ? $clog2(MODE_SLOTS) : 1;
   localparam int CNT_W   = $clog2(MODE_SLOTS + 1);
   localparam int CL_W    = (CNT_W > MCNT_W) ? CNT_W : MCNT_W;
   localparam int REM_W   = CNT_W + 1;
   localparam int EXT_W   = (MODE_W > SHOWN_W) ? MODE_W : SHOWN_W;
   localparam logic [1:0] PULSE_START = 2'(PULSE_LENGTH);

   logic [TICK_W-1:0]  ticks_per_day_ff, night_start_ff, night_end_ff;
   logic [LEVEL_W-1:0] full_brightness_ff, dim_brightness_ff;
   logic [MCNT_W-1:0]  mode_count_ff;

   logic [DAY_COUNTER_BITS-1:0] day_tick_ff, day_tick_in;
   logic                        night_flag_ff, night_flag_in;
   logic [LEVEL_W-1:0]          brightness_ff, brightness_in;
   logic                        pulse_on_ff, pulse_on_in;
   logic [1:0]                  pulse_left_ff, pulse_left_in;
   logic [ZONE_W-1:0]           last_zones_ff, last_zones_in;
   logic [MODE_W-1:0]           mode_number_ff, mode_number_in;
   logic                        mode_pending_ff, mode_pending_in;
   logic [MODE_W-1:0]           displayed_ff, displayed_in;
   logic                        refresh_in;

   logic                        rsp_valid_ff;
   lbnpc_pkg::rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   logic                        req_fire;
   logic [DAY_COUNTER_BITS-1:0] tick_inc;
   logic [CMP_W-1:0]            tick_cmp;
   logic                        tick_wrap;
   logic                        night_next;
   logic [lbnpc_pkg::LOAD_W-1:0] load;
   logic [ZONE_W-1:0]           rising;
   logic [CL_W-1:0]             count_wide;
   logic [CNT_W-1:0]            count_use;
   logic [MODE_W:0]             dividend;
   logic [REM_W-1:0]            rem;
   logic [EXT_W-1:0]            shown_ext;

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = !reset;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_day_ff   <= lbnpc_pkg::RST_TICKS_PER_DAY;
         night_start_ff     <= lbnpc_pkg::RST_NIGHT_START;
         night_end_ff       <= lbnpc_pkg::RST_NIGHT_END;
         full_brightness_ff <= lbnpc_pkg::RST_FULL_BRIGHTNESS;
         dim_brightness_ff  <= lbnpc_pkg::RST_DIM_BRIGHTNESS;
         mode_count_ff      <= lbnpc_pkg::RST_MODE_COUNT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lbnpc_pkg::CSR_TICKS_PER_DAY:   ticks_per_day_ff   <= csr_data[TICK_W-1:0];
            lbnpc_pkg::CSR_NIGHT_START:     night_start_ff     <= csr_data[TICK_W-1:0];
            lbnpc_pkg::CSR_NIGHT_END:       night_end_ff       <= csr_data[TICK_W-1:0];
            lbnpc_pkg::CSR_FULL_BRIGHTNESS: full_brightness_ff <= csr_data[LEVEL_W-1:0];
            lbnpc_pkg::CSR_DIM_BRIGHTNESS:  dim_brightness_ff  <= csr_data[LEVEL_W-1:0];
            lbnpc_pkg::CSR_MODE_COUNT:      mode_count_ff      <= csr_data[MCNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      tick_inc   = day_tick_ff + DAY_COUNTER_BITS'(1);
      tick_wrap  = CMP_W'(tick_inc) >= CMP_W'(ticks_per_day_ff);
      tick_cmp   = tick_wrap ? '0 : CMP_W'(tick_inc);
      night_next = (tick_cmp >= CMP_W'(night_start_ff)) || (tick_cmp < CMP_W'(night_end_ff));
      load = (req_payload.zone_levels[0] ? lbnpc_pkg::CAP_ZONE1_LOAD : '0)
           + (req_payload.zone_levels[1] ? lbnpc_pkg::CAP_ZONE_OTHER_LOAD : '0)
           + (req_payload.zone_levels[2] ? lbnpc_pkg::CAP_ZONE_OTHER_LOAD : '0);
      rising = req_payload.zone_levels & ~last_zones_ff;

      count_wide = CL_W'(mode_count_ff);
      if (count_wide == '0) begin
         count_wide = CL_W'(1);
      end else if (count_wide > CL_W'(MODE_SLOTS)) begin
         count_wide = CL_W'(MODE_SLOTS);
      end
      count_use = count_wide[CNT_W-1:0];
      dividend  = {1'b0, mode_number_ff} + (MODE_W+1)'(1);
      rem = '0;
      for (int i = MODE_W; i >= 0; i--) begin
         rem = {rem[REM_W-2:0], dividend[i]};
         if (rem >= REM_W'(count_use)) begin
            rem = rem - REM_W'(count_use);
         end
      end

      day_tick_in     = day_tick_ff;
      night_flag_in   = night_flag_ff;
      brightness_in   = brightness_ff;
      pulse_on_in     = pulse_on_ff;
      pulse_left_in   = pulse_left_ff;
      last_zones_in   = last_zones_ff;
      mode_number_in  = mode_number_ff;
      mode_pending_in = mode_pending_ff;
      displayed_in    = displayed_ff;
      refresh_in      = 1'b0;

      unique case (req_payload.kind)
         lbnpc_pkg::KIND_TICK: begin
            day_tick_in   = tick_cmp[DAY_COUNTER_BITS-1:0];
            night_flag_in = night_next;
            if (night_next != night_flag_ff) begin
               brightness_in = night_next ? '0 : full_brightness_ff;
               refresh_in    = 1'b1;
            end
            if (!night_next) begin
               if (load >= lbnpc_pkg::CAP_LIMIT) begin
                  brightness_in = dim_brightness_ff;
               end else if (!pulse_on_ff) begin
                  brightness_in = full_brightness_ff;
               end
            end
            if (pulse_on_ff && (pulse_left_ff != '0)) begin
               pulse_left_in = pulse_left_ff - 2'd1;
               if (pulse_left_ff == 2'd1) begin
                  pulse_on_in   = 1'b0;
                  brightness_in = night_next ? '0 : full_brightness_ff;
               end
            end
         end
         lbnpc_pkg::KIND_POLL: begin
            if ((rising != '0) && !night_flag_ff) begin
               pulse_on_in   = 1'b1;
               pulse_left_in = PULSE_START;
               brightness_in = lbnpc_pkg::PULSE_LEVEL;
            end
            last_zones_in = req_payload.zone_levels;
            if (mode_pending_ff) begin
               mode_pending_in = 1'b0;
               displayed_in    = mode_number_ff;
            end
            refresh_in = 1'b1;
         end
         lbnpc_pkg::KIND_BUTTON: begin
            mode_number_in  = rem[MODE_W-1:0];
            mode_pending_in = 1'b1;
         end
         lbnpc_pkg::KIND_UNUSED: begin
         end
      endcase

      shown_ext                 = EXT_W'(displayed_in);
      rsp_payload_in.brightness = brightness_in;
      rsp_payload_in.shown_mode = shown_ext[SHOWN_W-1:0];
      rsp_payload_in.night      = night_flag_in;
      rsp_payload_in.refresh    = refresh_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_tick_ff     <= '0;
         night_flag_ff   <= 1'b0;
         brightness_ff   <= lbnpc_pkg::RST_FULL_BRIGHTNESS;
         pulse_on_ff     <= 1'b0;
         pulse_left_ff   <= '0;
         last_zones_ff   <= '0;
         mode_number_ff  <= '0;
         mode_pending_ff <= 1'b0;
         displayed_ff    <= '0;
      end else if (req_fire) begin
         day_tick_ff     <= day_tick_in;
         night_flag_ff   <= night_flag_in;
         brightness_ff   <= brightness_in;
         pulse_on_ff     <= pulse_on_in;
         pulse_left_ff   <= pulse_left_in;
         last_zones_ff   <= last_zones_in;
         mode_number_ff  <= mode_number_in;
         mode_pending_ff <= mode_pending_in;
         displayed_ff    <= displayed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> sv/lbnpc_checker.sv
// ----------------------------------------------------------------------------
// lbnpc_checker: port-level checks for the night pulse controller
// Watches the req and rsp ports over time and reports violations.
// ----------------------------------------------------------------------------
module lbnpc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input lbnpc_pkg::req_payload_type req_payload,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input lbnpc_pkg::rsp_payload_type rsp_payload
);

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Stalled result transfer changed or dropped.");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid)
      else $error("Accepted event produced no result in the next cycle.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("Input accepted while a result was still waiting.");

   a_poll_refresh: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_payload.kind == lbnpc_pkg::KIND_POLL) |=> rsp_payload.refresh)
      else $error("Poll result did not flag a refresh.");

   a_quiet_kinds: assert property (@(posedge clock) disable iff (reset)
      req_fire && ((req_payload.kind == lbnpc_pkg::KIND_BUTTON) ||
                   (req_payload.kind == lbnpc_pkg::KIND_UNUSED))
      |=> !rsp_payload.refresh)
      else $error("Button or unused event flagged a refresh.");

endmodule

bind led_brightness_night_pulse_controller_top lbnpc_checker u_lbnpc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

>>> verif/tb_led_brightness_night_pulse_controller_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_brightness_night_pulse_controller_top: self-checking bench
// Drives events and register writes over valid/ready channels with random
// gaps, tracks the controller state alongside the block, and compares every
// result transfer field by field with the predicted lamp state.
// ----------------------------------------------------------------------------
module tb_led_brightness_night_pulse_controller_top;

   localparam int CYCLE_LIMIT    = 500000;
   localparam int LONG_HOLD      = 200;
   localparam int REPORT_LIMIT   = 20;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_EVENTS   = 130;
   localparam logic [lbnpc_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [lbnpc_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   lbnpc_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   lbnpc_pkg::rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [lbnpc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lbnpc_pkg::CSR_DATA_W-1:0] csr_data = '0;

   logic steady_flow = 1'b0;
   logic hold_off_ask = 1'b0;
   int unsigned stall_left = 0;
   int unsigned mismatches = 0;
   lbnpc_pkg::rsp_payload_type awaited[$];

   logic [lbnpc_pkg::TICK_W-1:0] day_count, day_len, night_from, night_to;
   logic [lbnpc_pkg::LEVEL_W-1:0] level, full_level, dim_level;
   logic [lbnpc_pkg::MODE_CNT_W-1:0] mode_limit;
   logic dark_now, glow_on, mode_waiting;
   logic [1:0] pulse_count;
   logic [lbnpc_pkg::ZONE_W-1:0] prev_zones;
   logic [lbnpc_pkg::SHOWN_W-1:0] mode_idx, mode_shown;

   led_brightness_night_pulse_controller_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 19) == 0) begin
         return $urandom_range(10, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   function automatic lbnpc_pkg::rsp_payload_type next_lamp_state(
         lbnpc_pkg::req_payload_type ev);
      lbnpc_pkg::rsp_payload_type r;
      logic dark_before;
      logic [lbnpc_pkg::LOAD_W-1:0] load;
      logic [lbnpc_pkg::ZONE_W-1:0] rising;
      int span;
      r = '0;
      case (ev.kind)
         lbnpc_pkg::KIND_TICK: begin
            dark_before = dark_now;
            day_count = day_count + lbnpc_pkg::TICK_W'(1);
            if (day_count >= day_len) begin
               day_count = '0;
            end
            dark_now = (day_count >= night_from) || (day_count < night_to);
            if (dark_now != dark_before) begin
               level = dark_now ? '0 : full_level;
               r.refresh = 1'b1;
            end
            if (!dark_now) begin
               load = (ev.zone_levels[0] ? lbnpc_pkg::CAP_ZONE1_LOAD : '0)
                    + (ev.zone_levels[1] ? lbnpc_pkg::CAP_ZONE_OTHER_LOAD : '0)
                    + (ev.zone_levels[2] ? lbnpc_pkg::CAP_ZONE_OTHER_LOAD : '0);
               if (load >= lbnpc_pkg::CAP_LIMIT) begin
                  level = dim_level;
               end else if (!glow_on) begin
                  level = full_level;
               end
            end
            if (glow_on && pulse_count != 2'd0) begin
               pulse_count = pulse_count - 2'd1;
               if (pulse_count == 2'd0) begin
                  glow_on = 1'b0;
                  level = dark_now ? '0 : full_level;
               end
            end
         end
         lbnpc_pkg::KIND_POLL: begin
            rising = ev.zone_levels & ~prev_zones;
            if (rising != '0 && !dark_now) begin
               glow_on = 1'b1;
               pulse_count = 2'(lbnpc_pkg::PULSE_LENGTH);
               level = lbnpc_pkg::PULSE_LEVEL;
            end
            prev_zones = ev.zone_levels;
            if (mode_waiting) begin
               mode_waiting = 1'b0;
               mode_shown = mode_idx;
            end
            r.refresh = 1'b1;
         end
         lbnpc_pkg::KIND_BUTTON: begin
            span = int'(mode_limit);
            if (span < 1) begin
               span = 1;
            end
            if (span > lbnpc_pkg::MODE_SLOTS) begin
               span = lbnpc_pkg::MODE_SLOTS;
            end
            mode_idx = lbnpc_pkg::SHOWN_W'((int'(mode_idx) + 1) % span);
            mode_waiting = 1'b1;
         end
         default: begin
         end
      endcase
      r.brightness = level;
      r.shown_mode = mode_shown;
      r.night = dark_now;
      return r;
   endfunction

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      lbnpc_pkg::rsp_payload_type want;
      if (reset) begin
         awaited.delete();
         day_len = lbnpc_pkg::RST_TICKS_PER_DAY;
         night_from = lbnpc_pkg::RST_NIGHT_START;
         night_to = lbnpc_pkg::RST_NIGHT_END;
         full_level = lbnpc_pkg::RST_FULL_BRIGHTNESS;
         dim_level = lbnpc_pkg::RST_DIM_BRIGHTNESS;
         mode_limit = lbnpc_pkg::RST_MODE_COUNT;
         day_count = '0;
         dark_now = 1'b0;
         level = lbnpc_pkg::RST_FULL_BRIGHTNESS;
         glow_on = 1'b0;
         pulse_count = '0;
         prev_zones = '0;
         mode_idx = '0;
         mode_waiting = 1'b0;
         mode_shown = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: result expected none, actual %p", $time, rsp_payload);
               end
            end else begin
               want = awaited.pop_front();
               report_field("brightness", 32'(want.brightness),
                            32'(rsp_payload.brightness));
               report_field("shown_mode", 32'(want.shown_mode),
                            32'(rsp_payload.shown_mode));
               report_field("night", 32'(want.night), 32'(rsp_payload.night));
               report_field("refresh", 32'(want.refresh), 32'(rsp_payload.refresh));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lbnpc_pkg::CSR_TICKS_PER_DAY:   day_len = csr_data;
               lbnpc_pkg::CSR_NIGHT_START:     night_from = csr_data;
               lbnpc_pkg::CSR_NIGHT_END:       night_to = csr_data;
               lbnpc_pkg::CSR_FULL_BRIGHTNESS: full_level = csr_data[lbnpc_pkg::LEVEL_W-1:0];
               lbnpc_pkg::CSR_DIM_BRIGHTNESS:  dim_level = csr_data[lbnpc_pkg::LEVEL_W-1:0];
               lbnpc_pkg::CSR_MODE_COUNT:
                  mode_limit = csr_data[lbnpc_pkg::MODE_CNT_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            awaited.push_back(next_lamp_state(req_payload));
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (hold_off_ask) begin
         hold_off_ask <= 1'b0;
         stall_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 99) < 12) begin
         stall_left <= pick_gap() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_event(input logic [1:0] kind,
                             input logic [lbnpc_pkg::ZONE_W-1:0] zones);
      int unsigned gap;
      gap = (!steady_flow && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= '{kind: kind, zone_levels: zones};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random_event();
      int unsigned pick;
      logic [1:0] kind;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         kind = lbnpc_pkg::KIND_TICK;
      end else if (pick < 80) begin
         kind = lbnpc_pkg::KIND_POLL;
      end else if (pick < 95) begin
         kind = lbnpc_pkg::KIND_BUTTON;
      end else begin
         kind = lbnpc_pkg::KIND_UNUSED;
      end
      send_event(kind, lbnpc_pkg::ZONE_W'($urandom_range(0, 7)));
   endtask

   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [lbnpc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [lbnpc_pkg::CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_settings(input logic [lbnpc_pkg::CSR_DATA_W-1:0] ticks, n_start,
                                 n_end, full, dim, modes);
      write_reg(lbnpc_pkg::CSR_TICKS_PER_DAY, ticks);
      write_reg(lbnpc_pkg::CSR_NIGHT_START, n_start);
      write_reg(lbnpc_pkg::CSR_NIGHT_END, n_end);
      write_reg(lbnpc_pkg::CSR_FULL_BRIGHTNESS, full);
      write_reg(lbnpc_pkg::CSR_DIM_BRIGHTNESS, dim);
      write_reg(lbnpc_pkg::CSR_MODE_COUNT, modes);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_event(lbnpc_pkg::KIND_TICK, 3'b000);
      send_event(lbnpc_pkg::KIND_POLL, 3'b111);
      send_event(lbnpc_pkg::KIND_TICK, 3'b000);
      send_event(lbnpc_pkg::KIND_TICK, 3'b000);
      send_event(lbnpc_pkg::KIND_BUTTON, 3'b000);
      send_event(lbnpc_pkg::KIND_POLL, 3'b000);
      send_event(lbnpc_pkg::KIND_UNUSED, 3'b101);
   endtask

   task automatic test_night_window();
      wait_for_quiet();
      apply_settings(17'd4, 17'd2, 17'd1, 17'd200, 17'd17, 17'd3);
      send_event(lbnpc_pkg::KIND_TICK, 3'b011);
      send_event(lbnpc_pkg::KIND_POLL, 3'b111);
      for (int i = 0; i < 4; i++) begin
         send_event(lbnpc_pkg::KIND_TICK, i[0] ? 3'b011 : 3'b111);
      end
      repeat (3) send_event(lbnpc_pkg::KIND_BUTTON, 3'b000);
      send_event(lbnpc_pkg::KIND_POLL, 3'b000);
   endtask

   task automatic test_extremes();
      wait_for_quiet();
      apply_settings(17'd0, 17'd0, 17'h1FFFF, 17'd0, 17'd255, 17'h1FFFF);
      send_event(lbnpc_pkg::KIND_TICK, 3'b111);
      send_event(lbnpc_pkg::KIND_BUTTON, 3'b000);
      send_event(lbnpc_pkg::KIND_POLL, 3'b010);
      wait_for_quiet();
      apply_settings(17'h1FFFF, 17'h1FFFF, 17'd0, 17'h1FFFF, 17'h1FF00, 17'h1FFF0);
      send_event(lbnpc_pkg::KIND_TICK, 3'b000);
      send_event(lbnpc_pkg::KIND_TICK, 3'b111);
      send_event(lbnpc_pkg::KIND_BUTTON, 3'b000);
      send_event(lbnpc_pkg::KIND_POLL, 3'b000);
   endtask

   task automatic test_unused_indexes();
      wait_for_quiet();
      write_reg(CSR_SPARE_LOW, 17'h1FFFF);
      write_reg(CSR_SPARE_HIGH, 17'h1FFFF);
      csr_valid <= 1'b0;
      send_event(lbnpc_pkg::KIND_TICK, 3'b000);
      send_event(lbnpc_pkg::KIND_POLL, 3'b001);
   endtask

   task automatic test_cap_during_pulse();
      wait_for_quiet();
      apply_settings(17'd1000, 17'h1FFFF, 17'd0, 17'd100, 17'd30, 17'd8);
      send_event(lbnpc_pkg::KIND_POLL, 3'b000);
      send_event(lbnpc_pkg::KIND_POLL, 3'b111);
      send_event(lbnpc_pkg::KIND_TICK, 3'b111);
      send_event(lbnpc_pkg::KIND_TICK, 3'b000);
   endtask

   task automatic test_random_settings();
      logic [lbnpc_pkg::CSR_DATA_W-1:0] ticks, n_start, n_end;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_quiet();
         if (phase == 0) begin
            apply_settings(17'd2, 17'd1, 17'd0, 17'd255, 17'd0, 17'd1);
         end else if (phase == 1) begin
            apply_settings(17'h1FFFF, 17'd3, 17'd1, 17'd0, 17'd255, 17'd8);
         end else begin
            case ($urandom_range(0, 7))
               0: ticks = '0;
               1: ticks = 17'h1FFFF;
               default: ticks = lbnpc_pkg::CSR_DATA_W'($urandom_range(1, 40));
            endcase
            n_start = lbnpc_pkg::CSR_DATA_W'(($urandom_range(0, 7) == 0) ?
                         $urandom_range(0, 17'h1FFFF) : $urandom_range(0, 44));
            n_end = lbnpc_pkg::CSR_DATA_W'(($urandom_range(0, 7) == 0) ?
                       $urandom_range(0, 17'h1FFFF) : $urandom_range(0, 44));
            apply_settings(ticks, n_start, n_end,
                           lbnpc_pkg::CSR_DATA_W'($urandom_range(0, 17'h1FFFF)),
                           lbnpc_pkg::CSR_DATA_W'($urandom_range(0, 17'h1FFFF)),
                           lbnpc_pkg::CSR_DATA_W'($urandom_range(0, 17'h1FFFF)));
         end
         repeat (PHASE_EVENTS) send_random_event();
      end
   endtask

   task automatic test_back_to_back();
      wait_for_quiet();
      steady_flow <= 1'b1;
      repeat (80) send_random_event();
      steady_flow <= 1'b0;
   endtask

   task automatic test_input_stall();
      wait_for_quiet();
      hold_off_ask <= 1'b1;
      steady_flow <= 1'b1;
      repeat (30) send_random_event();
      steady_flow <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_night_window();
      test_extremes();
      test_unused_indexes();
      test_cap_during_pulse();
      test_random_settings();
      test_back_to_back();
      test_input_stall();
      wait_for_quiet();
      if (mismatches == 0 && awaited.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
